[rtl/aabb_pkg.sv]
`timescale 1ns / 1ps

package aabb_pkg;

   // Coordinate and matrix formats
   localparam int CoordW    = 16;              // signed Q12.4 coordinate
   localparam int CoefW     = 16;              // signed Q4.12 coefficient
   localparam int CoefFrac  = 12;              // fraction bits of a coefficient
   localparam int RowW      = 4 * CoefW;       // three coefficients and a translation
   localparam int ProdW     = CoordW + CoefW;  // one coefficient times one coordinate
   localparam int SumW      = ProdW + 2;       // three products, translation and rounding
   localparam int ShiftW    = SumW - CoefFrac; // sum brought back to Q12.4
   localparam int NumStages = 4;

   typedef logic signed [CoordW-1:0] coord_type;
   typedef logic signed [CoefW-1:0]  coef_type;
   typedef logic signed [ProdW-1:0]  prod_type;
   typedef logic signed [SumW-1:0]   sum_type;
   typedef logic        [RowW-1:0]   row_type;

   // Input item
   typedef struct packed {
      coord_type box_min_x;
      coord_type box_min_y;
      coord_type box_min_z;
      coord_type box_max_x;
      coord_type box_max_y;
      coord_type box_max_z;
      row_type   row_x;
      row_type   row_y;
      row_type   row_z;
   } req_item_type;

   // Result item
   typedef struct packed {
      coord_type out_min_x;
      coord_type out_min_y;
      coord_type out_min_z;
      coord_type out_max_x;
      coord_type out_max_y;
      coord_type out_max_z;
   } rsp_item_type;

   // Per-stage load enables from the pipeline control
   typedef struct packed {
      logic [NumStages-1:0] load;
   } stage_ctrl_type;

endpackage

[rtl/aabb_axis.sv]
`timescale 1ns / 1ps

// One output axis: the bounds of c.p + t over the eight corners. The sum separates
// per coordinate, so its minimum is the sum of the per-term minimums, and rounding
// and saturation keep order.
module aabb_axis (
   input  logic                    clock,
   input  aabb_pkg::stage_ctrl_type ctrl,
   input  aabb_pkg::row_type       row,
   input  aabb_pkg::coord_type     lo_x,
   input  aabb_pkg::coord_type     lo_y,
   input  aabb_pkg::coord_type     lo_z,
   input  aabb_pkg::coord_type     hi_x,
   input  aabb_pkg::coord_type     hi_y,
   input  aabb_pkg::coord_type     hi_z,
   output aabb_pkg::coord_type     out_min,
   output aabb_pkg::coord_type     out_max
);
   import aabb_pkg::*;

   localparam logic signed [ShiftW-1:0] SatHi = ShiftW'((1 <<< (CoordW - 1)) - 1);
   localparam logic signed [ShiftW-1:0] SatLo = -ShiftW'(1 <<< (CoordW - 1));
   localparam sum_type RoundBit = SumW'(1 <<< (CoefFrac - 1));

   coef_type  coef [3];
   coord_type lo   [3];
   coord_type hi   [3];
   coef_type  trans;

   prod_type  prod_lo_in [3];
   prod_type  prod_hi_in [3];
   prod_type  prod_lo_ff [3];
   prod_type  prod_hi_ff [3];
   coef_type  trans1_ff;

   prod_type  term_min_in [3];
   prod_type  term_max_in [3];
   prod_type  term_min_ff [3];
   prod_type  term_max_ff [3];
   coef_type  trans2_ff;

   sum_type   sum_min_in;
   sum_type   sum_max_in;
   sum_type   sum_min_ff;
   sum_type   sum_max_ff;

   logic signed [ShiftW-1:0] shift_min;
   logic signed [ShiftW-1:0] shift_max;
   coord_type out_min_in;
   coord_type out_max_in;
   coord_type out_min_ff;
   coord_type out_max_ff;

   // Split the row into coefficients and translation
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         coef[j] = row[j*CoefW +: CoefW];
      end
      trans = row[3*CoefW +: CoefW];
      lo[0] = lo_x;
      lo[1] = lo_y;
      lo[2] = lo_z;
      hi[0] = hi_x;
      hi[1] = hi_y;
      hi[2] = hi_z;
   end

   // Stage 1: both products per term
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         prod_lo_in[j] = ProdW'(coef[j]) * ProdW'(lo[j]);
         prod_hi_in[j] = ProdW'(coef[j]) * ProdW'(hi[j]);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[0]) begin
         prod_lo_ff <= prod_lo_in;
         prod_hi_ff <= prod_hi_in;
         trans1_ff  <= trans;
      end
   end

   // Stage 2: pick the smaller and larger product per term
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         if (prod_lo_ff[j] < prod_hi_ff[j]) begin
            term_min_in[j] = prod_lo_ff[j];
            term_max_in[j] = prod_hi_ff[j];
         end else begin
            term_min_in[j] = prod_hi_ff[j];
            term_max_in[j] = prod_lo_ff[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[1]) begin
         term_min_ff <= term_min_in;
         term_max_ff <= term_max_in;
         trans2_ff   <= trans1_ff;
      end
   end

   // Stage 3: add terms, translation and the rounding half
   always_comb begin
      sum_type t_ext;
      t_ext      = {SumW'(trans2_ff)} <<< CoefFrac;
      sum_min_in = SumW'(term_min_ff[0]) + SumW'(term_min_ff[1]) + SumW'(term_min_ff[2])
                 + t_ext + RoundBit;
      sum_max_in = SumW'(term_max_ff[0]) + SumW'(term_max_ff[1]) + SumW'(term_max_ff[2])
                 + t_ext + RoundBit;
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[2]) begin
         sum_min_ff <= sum_min_in;
         sum_max_ff <= sum_max_in;
      end
   end

   // Stage 4: drop the extra fraction with floor and saturate
   always_comb begin
      shift_min = sum_min_ff[SumW-1:CoefFrac];
      shift_max = sum_max_ff[SumW-1:CoefFrac];
      priority if (shift_min > SatHi) begin
         out_min_in = SatHi[CoordW-1:0];
      end else if (shift_min < SatLo) begin
         out_min_in = SatLo[CoordW-1:0];
      end else begin
         out_min_in = shift_min[CoordW-1:0];
      end
      priority if (shift_max > SatHi) begin
         out_max_in = SatHi[CoordW-1:0];
      end else if (shift_max < SatLo) begin
         out_max_in = SatLo[CoordW-1:0];
      end else begin
         out_max_in = shift_max[CoordW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[3]) begin
         out_min_ff <= out_min_in;
         out_max_ff <= out_max_in;
      end
   end

   assign out_min = out_min_ff;
   assign out_max = out_max_ff;

endmodule

[rtl/aabb_affine_transform.sv]
`timescale 1ns / 1ps
// Four register stages (multiply, compare, add, round and saturate) carry an
// accepted item to its result on rsp_item. Throughput: one item per cycle while
// the result is not stalled; each stage advances whenever the one after it is
// empty or moving, so bubbles close up under a stalled result.
// Reset clears the stage valid bits only; data registers are not reset.
module aabb_affine_transform (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  aabb_pkg::req_item_type req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output aabb_pkg::rsp_item_type rsp_item
);
   import aabb_pkg::*;

   logic [NumStages-1:0] valid_ff;
   logic [NumStages-1:0] valid_in;
   logic [NumStages-1:0] ready;
   stage_ctrl_type       ctrl;

   // Work out which stages may load this cycle
   always_comb begin
      ready[NumStages-1] = !valid_ff[NumStages-1] || !rsp_stall;
      for (int k = NumStages - 2; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
      ctrl.load = ready;
   end

   // Advance the valid bits with the data
   always_comb begin
      valid_in[0] = req_valid;
      for (int k = 1; k < NumStages; k++) begin
         valid_in[k] = valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NumStages; k++) begin
            if (ready[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   assign req_stall = !ready[0];
   assign rsp_valid = valid_ff[NumStages-1];

   // One datapath per output axis
   aabb_axis u_axis_x (
      .clock   (clock),
      .ctrl    (ctrl),
      .row     (req_item.row_x),
      .lo_x    (req_item.box_min_x),
      .lo_y    (req_item.box_min_y),
      .lo_z    (req_item.box_min_z),
      .hi_x    (req_item.box_max_x),
      .hi_y    (req_item.box_max_y),
      .hi_z    (req_item.box_max_z),
      .out_min (rsp_item.out_min_x),
      .out_max (rsp_item.out_max_x)
   );

   aabb_axis u_axis_y (
      .clock   (clock),
      .ctrl    (ctrl),
      .row     (req_item.row_y),
      .lo_x    (req_item.box_min_x),
      .lo_y    (req_item.box_min_y),
      .lo_z    (req_item.box_min_z),
      .hi_x    (req_item.box_max_x),
      .hi_y    (req_item.box_max_y),
      .hi_z    (req_item.box_max_z),
      .out_min (rsp_item.out_min_y),
      .out_max (rsp_item.out_max_y)
   );

   aabb_axis u_axis_z (
      .clock   (clock),
      .ctrl    (ctrl),
      .row     (req_item.row_z),
      .lo_x    (req_item.box_min_x),
      .lo_y    (req_item.box_min_y),
      .lo_z    (req_item.box_min_z),
      .hi_x    (req_item.box_max_x),
      .hi_y    (req_item.box_max_y),
      .hi_z    (req_item.box_max_z),
      .out_min (rsp_item.out_min_z),
      .out_max (rsp_item.out_max_z)
   );

   // A free output side never holds off the input
   a_no_stall_when_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("input stalled while output is free");

   // The result box is never inverted
   a_min_le_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.out_min_x <= rsp_item.out_max_x) &&
                    (rsp_item.out_min_y <= rsp_item.out_max_y) &&
                    (rsp_item.out_min_z <= rsp_item.out_max_z))
      else $error("result minimum above maximum");

   // An item accepted into an empty pipeline reaches rsp_valid if the output is not stalled on its way through
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && valid_ff == '0 && !rsp_stall) ##1 !rsp_stall ##1
      !rsp_stall ##1 !rsp_stall |=> rsp_valid)
      else $error("item lost in pipeline");

endmodule
